// File: hw/rtl/ssbr_pkg.sv
// Package for the scroll strip buffer ring: operation codes, result codes,
// sequencer states, the stored strip entry type and default sizes.
// No dependencies.
package ssbr_pkg;

   localparam int NUM_STRIPS_DEFAULT = 4;
   localparam int ROW_W = 32;
   localparam int HEIGHT_W = 16;
   localparam int KIND_W = 2;
   localparam int POS_W = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_REPOSITION = 2'd0,
      KIND_VALIDATE = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_INVALIDATE = 2'd3
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      RSP_STRIP_INVALIDATED = 2'd0,
      RSP_RANGE_REPORT = 2'd1,
      RSP_DONE = 2'd2
   } rsp_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_TOP,
      ST_RD_BOT,
      ST_CAP_BOT,
      ST_DECIDE,
      ST_ROLL_UP,
      ST_ROLL_DN,
      ST_INVAL,
      ST_RD,
      ST_ISECT,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [ROW_W-1:0] origin;
      logic signed [ROW_W-1:0] valid_start;
      logic signed [ROW_W-1:0] valid_end;
   } strip_entry_type;

   localparam int ENTRY_W = $bits(strip_entry_type);

endpackage

// File: hw/rtl/ssbr_chan_if.sv
// Valid/ready channel interfaces for the request and response transactions
// of the scroll strip buffer ring. Depends on ssbr_pkg.
interface ssbr_req_if;
   import ssbr_pkg::*;

   logic valid;
   logic ready;
   logic [KIND_W-1:0] kind;
   logic signed [ROW_W-1:0] range_start;
   logic signed [ROW_W-1:0] range_end;

   modport source (output valid, kind, range_start, range_end, input ready);
   modport sink (input valid, kind, range_start, range_end, output ready);
endinterface

interface ssbr_rsp_if;
   import ssbr_pkg::*;

   logic valid;
   logic ready;
   logic [KIND_W-1:0] result_kind;
   logic [POS_W-1:0] strip_position;
   logic signed [ROW_W-1:0] invalid_start;
   logic signed [ROW_W-1:0] invalid_end;
   logic window_changed;
   logic roll_overflow;
   logic last;

   modport source (output valid, result_kind, strip_position, invalid_start, invalid_end,
                   window_changed, roll_overflow, last, input ready);
   modport sink (input valid, result_kind, strip_position, invalid_start, invalid_end,
                 window_changed, roll_overflow, last, output ready);
endinterface

// File: hw/rtl/ssbr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Default sizes come from ssbr_pkg.
module ssbr_ram #(
   parameter int WIDTH = ssbr_pkg::ENTRY_W,
   parameter int DEPTH = ssbr_pkg::NUM_STRIPS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/scroll_strip_buffer_ring_unit.sv
// Scroll strip buffer ring: a ring of strip buffers covering a scrolling window.
// Depends on ssbr_pkg, ssbr_chan_if and ssbr_ram.
//
// Usage: each request transaction on req_chan carries one operation (reposition,
// validate, query, invalidate). Its results leave on rsp_chan in order, and the
// last one is always a done transaction with last set. A reposition reports each
// recycled strip, a query reports one invalid range per strip and an invalidate
// reports every strip before the done transaction. csr_write_enable loads the
// strip height from csr_write_data; write it only while the block is idle.
// The strip records live in one RAM of NUM_STRIPS entries with a registered read.
// A request is taken only while the sequencer is idle, which it is again from the
// edge that loads the done transaction. An unchanged reposition goes straight to
// the done transaction; any other reads the top and bottom strip origins, then
// rolls up or down, finds no move, or re-places every strip when the new window
// lies outside. Invalidate rewrites each strip in turn; validate and query take
// each strip through a read, a combine and a write-back or report pass.
// A response waits in an output register, so a stalled receiver holds the
// sequencer only when a further result is due.
// Reset clears the window, the ring head and the per-entry valid bits; an entry
// never written reads as zero, so no clearing pass is needed.
module scroll_strip_buffer_ring_unit #(
   parameter int NUM_STRIPS = ssbr_pkg::NUM_STRIPS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   ssbr_req_if.sink                       req_chan,
   ssbr_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [ssbr_pkg::HEIGHT_W-1:0]  csr_write_data
);
   import ssbr_pkg::*;

   localparam int IDX_W = $clog2(NUM_STRIPS);
   localparam int CNT_W = $clog2(NUM_STRIPS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_STRIPS - 1);
   localparam logic [IDX_W:0] N_EXT = (IDX_W + 1)'(NUM_STRIPS);
   localparam logic [CNT_W-1:0] ROLL_CAP = CNT_W'(NUM_STRIPS);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_STRIPS - 1);

   state_type state_ff, state_in;
   req_kind_type kind_ff, kind_in;
   logic signed [ROW_W-1:0] rs_ff, rs_in, re_ff, re_in;
   logic signed [ROW_W-1:0] ws_ff, ws_in, we_ff, we_in;
   logic [IDX_W-1:0] head_ff, head_in, pos_ff, pos_in;
   logic [CNT_W-1:0] rolls_ff, rolls_in;
   logic signed [ROW_W-1:0] top_ff, top_in, bot_ff, bot_in, acc_ff, acc_in;
   logic signed [ROW_W-1:0] org_ff, org_in, vs_ff, vs_in, ve_ff, ve_in;
   logic signed [ROW_W-1:0] gs_ff, gs_in, ge_ff, ge_in;
   logic chg_ff, chg_in, ovf_ff, ovf_in;
   logic [HEIGHT_W-1:0] height_ff;
   logic [NUM_STRIPS-1:0] entry_valid_ff, entry_valid_in;
   logic rd_ok_ff;

   logic rsp_valid_ff, rsp_valid_in;
   rsp_kind_type rsp_kind_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic signed [ROW_W-1:0] rsp_is_ff, rsp_ie_ff;
   logic rsp_chg_ff, rsp_ovf_ff, rsp_last_ff;

   logic emit;
   rsp_kind_type e_kind;
   logic [POS_W-1:0] e_pos;
   logic signed [ROW_W-1:0] e_is, e_ie;
   logic e_chg, e_ovf, e_last;

   logic ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   strip_entry_type ram_wr_data, ram_rd_data, rd_entry;

   logic accept, out_free;
   logic signed [33:0] h34, bot_h, top_minus, o_h, g_e34;
   logic signed [ROW_W-1:0] g_s;
   logic g_empty;
   logic signed [ROW_W-1:0] s1, e1, s2, e2, q_s, q_e;
   logic emp1, emp2;
   logic up_cond, dn_cond, outside;

   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] pos);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= N_EXT) begin
         sum = sum - N_EXT;
      end
      return sum[IDX_W-1:0];
   endfunction

   ssbr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_STRIPS)
   ) u_strip_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = rd_ok_ff ? ram_rd_data : '0;
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign h34 = 34'(signed'({1'b0, height_ff}));
   assign bot_h = 34'(bot_ff) + h34;
   assign top_minus = 34'(top_ff) - h34;
   assign up_cond = top_ff > rs_ff;
   assign dn_cond = bot_h < 34'(re_ff);
   assign outside = (top_ff > re_ff) || (bot_h <= 34'(rs_ff));

   assign o_h = 34'(rd_entry.origin) + h34;
   assign g_s = (ws_ff > rd_entry.origin) ? ws_ff : rd_entry.origin;
   assign g_e34 = (34'(we_ff) < o_h) ? 34'(we_ff) : o_h;
   assign g_empty = g_e34 <= 34'(g_s);

   assign s1 = (rs_ff > gs_ff) ? rs_ff : gs_ff;
   assign e1 = (vs_ff < ge_ff) ? vs_ff : ge_ff;
   assign emp1 = e1 <= s1;
   assign s2 = (ve_ff > gs_ff) ? ve_ff : gs_ff;
   assign e2 = (re_ff < ge_ff) ? re_ff : ge_ff;
   assign emp2 = e2 <= s2;

   always_comb begin
      if (!emp1) begin
         q_s = s1;
         q_e = e1;
      end else if (!emp2) begin
         q_s = s2;
         q_e = e2;
      end else begin
         q_s = '0;
         q_e = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      rs_in = rs_ff;
      re_in = re_ff;
      ws_in = ws_ff;
      we_in = we_ff;
      head_in = head_ff;
      pos_in = pos_ff;
      rolls_in = rolls_ff;
      top_in = top_ff;
      bot_in = bot_ff;
      acc_in = acc_ff;
      org_in = org_ff;
      vs_in = vs_ff;
      ve_in = ve_ff;
      gs_in = gs_ff;
      ge_in = ge_ff;
      chg_in = chg_ff;
      ovf_in = ovf_ff;
      emit = 1'b0;
      e_kind = RSP_DONE;
      e_pos = '0;
      e_is = '0;
      e_ie = '0;
      e_chg = 1'b0;
      e_ovf = 1'b0;
      e_last = 1'b0;
      ram_wr_en = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_en = 1'b0;
      ram_rd_addr = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_kind_type'(req_chan.kind);
               rs_in = req_chan.range_start;
               re_in = req_chan.range_end;
               chg_in = 1'b0;
               ovf_in = 1'b0;
               pos_in = '0;
               rolls_in = '0;
               case (req_kind_type'(req_chan.kind))
                  KIND_REPOSITION: begin
                     if (req_chan.range_start == ws_ff && req_chan.range_end == we_ff) begin
                        state_in = ST_DONE;
                     end else begin
                        ws_in = req_chan.range_start;
                        we_in = req_chan.range_end;
                        chg_in = 1'b1;
                        state_in = ST_RD_TOP;
                     end
                  end
                  KIND_VALIDATE, KIND_QUERY: begin
                     state_in = ST_RD;
                  end
                  KIND_INVALIDATE: begin
                     acc_in = ROW_W'(34'(ws_ff) - h34);
                     state_in = ST_INVAL;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RD_TOP: begin
            ram_rd_en = 1'b1;
            ram_rd_addr = slot_of(head_ff, '0);
            state_in = ST_RD_BOT;
         end
         ST_RD_BOT: begin
            ram_rd_en = 1'b1;
            ram_rd_addr = slot_of(head_ff, LAST_IDX);
            top_in = rd_entry.origin;
            state_in = ST_CAP_BOT;
         end
         ST_CAP_BOT: begin
            bot_in = rd_entry.origin;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (outside) begin
               acc_in = ROW_W'(34'(rs_ff) - h34);
               state_in = ST_INVAL;
            end else begin
               state_in = ST_ROLL_UP;
            end
         end
         ST_ROLL_UP: begin
            if (up_cond) begin
               if (rolls_ff == ROLL_CAP) begin
                  ovf_in = 1'b1;
                  state_in = ST_DONE;
               end else if (out_free) begin
                  head_in = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
                  top_in = top_minus[ROW_W-1:0];
                  rolls_in = rolls_ff + 1'b1;
                  ram_wr_en = 1'b1;
                  ram_wr_addr = head_in;
                  ram_wr_data = '{origin: top_minus[ROW_W-1:0], valid_start: '0,
                                  valid_end: '0};
                  emit = 1'b1;
                  e_kind = RSP_STRIP_INVALIDATED;
               end
            end else if (rolls_ff == '0) begin
               state_in = ST_ROLL_DN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ROLL_DN: begin
            if (dn_cond) begin
               if (rolls_ff == ROLL_CAP) begin
                  ovf_in = 1'b1;
                  state_in = ST_DONE;
               end else if (out_free) begin
                  head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
                  bot_in = bot_h[ROW_W-1:0];
                  rolls_in = rolls_ff + 1'b1;
                  ram_wr_en = 1'b1;
                  ram_wr_addr = head_ff;
                  ram_wr_data = '{origin: bot_h[ROW_W-1:0], valid_start: '0,
                                  valid_end: '0};
                  emit = 1'b1;
                  e_kind = RSP_STRIP_INVALIDATED;
                  e_pos = LAST_POS;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_INVAL: begin
            if (out_free) begin
               ram_wr_en = 1'b1;
               ram_wr_addr = slot_of(head_ff, pos_ff);
               ram_wr_data = '{origin: acc_ff, valid_start: '0, valid_end: '0};
               acc_in = ROW_W'(34'(acc_ff) + h34);
               emit = 1'b1;
               e_kind = RSP_STRIP_INVALIDATED;
               e_pos = POS_W'(pos_ff);
               pos_in = pos_ff + 1'b1;
               if (pos_ff == LAST_IDX) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RD: begin
            ram_rd_en = 1'b1;
            ram_rd_addr = slot_of(head_ff, pos_ff);
            state_in = ST_ISECT;
         end
         ST_ISECT: begin
            org_in = rd_entry.origin;
            vs_in = rd_entry.valid_start;
            ve_in = rd_entry.valid_end;
            gs_in = g_empty ? '0 : g_s;
            ge_in = g_empty ? '0 : g_e34[ROW_W-1:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (kind_ff == KIND_VALIDATE) begin
               ram_wr_en = 1'b1;
               ram_wr_addr = slot_of(head_ff, pos_ff);
               ram_wr_data = '{origin: org_ff, valid_start: gs_ff, valid_end: ge_ff};
               pos_in = pos_ff + 1'b1;
               state_in = (pos_ff == LAST_IDX) ? ST_DONE : ST_RD;
            end else if (out_free) begin
               emit = 1'b1;
               e_kind = RSP_RANGE_REPORT;
               e_pos = POS_W'(pos_ff);
               e_is = q_s;
               e_ie = q_e;
               pos_in = pos_ff + 1'b1;
               state_in = (pos_ff == LAST_IDX) ? ST_DONE : ST_RD;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               emit = 1'b1;
               e_kind = RSP_DONE;
               e_chg = chg_ff;
               e_ovf = ovf_ff;
               e_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (ram_wr_en) begin
         entry_valid_in[ram_wr_addr] = 1'b1;
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ws_ff <= '0;
         we_ff <= '0;
         head_ff <= '0;
         height_ff <= '0;
         entry_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ws_ff <= ws_in;
         we_ff <= we_in;
         head_ff <= head_in;
         if (csr_write_enable) begin
            height_ff <= csr_write_data;
         end
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      rs_ff <= rs_in;
      re_ff <= re_in;
      pos_ff <= pos_in;
      rolls_ff <= rolls_in;
      top_ff <= top_in;
      bot_ff <= bot_in;
      acc_ff <= acc_in;
      org_ff <= org_in;
      vs_ff <= vs_in;
      ve_ff <= ve_in;
      gs_ff <= gs_in;
      ge_ff <= ge_in;
      chg_ff <= chg_in;
      ovf_ff <= ovf_in;
      if (ram_rd_en) begin
         rd_ok_ff <= entry_valid_ff[ram_rd_addr];
      end
      if (emit) begin
         rsp_kind_ff <= e_kind;
         rsp_pos_ff <= e_pos;
         rsp_is_ff <= e_is;
         rsp_ie_ff <= e_ie;
         rsp_chg_ff <= e_chg;
         rsp_ovf_ff <= e_ovf;
         rsp_last_ff <= e_last;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.result_kind = rsp_kind_ff;
   assign rsp_chan.strip_position = rsp_pos_ff;
   assign rsp_chan.invalid_start = rsp_is_ff;
   assign rsp_chan.invalid_end = rsp_ie_ff;
   assign rsp_chan.window_changed = rsp_chg_ff;
   assign rsp_chan.roll_overflow = rsp_ovf_ff;
   assign rsp_chan.last = rsp_last_ff;

`ifndef SYNTH
   // A new request is never taken in the cycle right after one was accepted.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("request accepted while an operation was in progress");

   // The ring never recycles more strips than it holds within one reposition.
   a_roll_cap: assert property (@(posedge clock) disable iff (reset)
      rolls_ff <= ROLL_CAP || state_ff == ST_IDLE)
      else $error("roll count exceeded the strip count");

   // The ring head moves only while rolling.
   a_head_moves: assert property (@(posedge clock) disable iff (reset)
      (!$stable(head_ff) && !$past(reset)) |->
         ($past(state_ff) == ST_ROLL_UP || $past(state_ff) == ST_ROLL_DN))
      else $error("ring head changed outside a roll");
`endif

endmodule
